// ===== rtl/sfe_pkg.sv =====
// ----------------------------------------------------------------------------
// sfe_pkg
// Shared constants, types and functions for the scope frame encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package sfe_pkg;

  // Sample saturation limits (the most negative 16-bit code is never produced).
  localparam logic signed [31:0] SAMPLE_MAX = 32'sd32767;
  localparam logic signed [31:0] SAMPLE_MIN = -32'sd32767;

  // Reflected CRC-16 settings.
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  // Frame layout: eight data bytes, then CRC low and CRC high.
  localparam int          FRAME_LEN  = 10;
  localparam int          DATA_LEN   = 8;
  localparam int          IDX_W      = 4;
  localparam logic [3:0]  IDX_FIRST  = 4'd0;
  localparam logic [3:0]  IDX_CRC_LO = 4'd8;
  localparam logic [3:0]  IDX_CRC_HI = 4'd9;

  // Default depth of the queue between front and back.
  localparam int          QUEUE_DEPTH = 2;

  // Four clamped 16-bit words, sample_a in the lowest bits.
  typedef logic [63:0] frame_words_t;

  // Write side of the queue, driven by the front.
  typedef struct packed {
    logic         valid;
    frame_words_t words;
  } q_wr_t;

  // Read side of the queue, seen by the back.
  typedef struct packed {
    logic         valid;
    frame_words_t words;
  } q_rd_t;

  // Saturate a 32-bit signed sample to -32767..32767 and return its 16 bits.
  function automatic logic [15:0] clamp_word(input logic signed [31:0] s);
    logic signed [31:0] v;
    v = s;
    if (s > SAMPLE_MAX) begin
      v = SAMPLE_MAX;
    end else if (s < SAMPLE_MIN) begin
      v = SAMPLE_MIN;
    end
    return v[15:0];
  endfunction

  // One byte through the reflected CRC-16, LSB first.
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/scope_frame_encoder_crc16.sv =====
// ----------------------------------------------------------------------------
// scope_frame_encoder_crc16
// Four-channel sample framer with a reflected CRC-16 trailer.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel takes one item of four signed 32-bit samples. Each
//   sample is saturated to -32767..32767 and packed as a little-endian
//   16-bit word. The output channel sends ten bytes per item: eight data
//   bytes, then CRC low and CRC high (poly 0xA001, init 0xFFFF, no final
//   XOR). out_tlast is high on the CRC high byte.
//   The first byte passes through the queue, the frame register of the
//   back and the output register. Throughput: one byte per cycle while
//   out_tready is high, set by the byte-wide output register; frames follow
//   each other with no gap. A queue of QUEUE_DEPTH items sits between the
//   input and the byte serializer, so new items are taken while a frame is
//   being sent. When the receiver stalls, the current byte holds and the
//   queue fills; in_tready drops only when the queue is full.
//   Reset (synchronous, active low) empties the queue and drops out_tvalid.
// ----------------------------------------------------------------------------
`default_nettype none

module scope_frame_encoder_crc16 #(
  parameter int QUEUE_DEPTH = sfe_pkg::QUEUE_DEPTH
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_tvalid,
  output logic               in_tready,
  input  wire logic [127:0]  in_tdata,   // sample_a[31:0], sample_b, sample_c, sample_d
  output logic               out_tvalid,
  input  wire logic          out_tready,
  output logic [7:0]         out_tdata,  // frame_byte[7:0]
  output logic               out_tlast   // frame_end
);

  sfe_pkg::q_wr_t q_wr;
  sfe_pkg::q_rd_t q_rd;
  logic           q_full;
  logic           q_pop;

  sfe_front u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .q_full    (q_full),
    .q_wr      (q_wr)
  );

  sfe_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_wr   (q_wr),
    .q_full (q_full),
    .q_rd   (q_rd),
    .q_pop  (q_pop)
  );

  sfe_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_rd       (q_rd),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

`default_nettype wire

// ===== rtl/sfe_front.sv =====
// ----------------------------------------------------------------------------
// sfe_front
// Accepts sample items, saturates each channel and pushes the packed
// words into the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module sfe_front (
  input  wire logic           in_tvalid,
  output logic                in_tready,
  input  wire logic [127:0]   in_tdata,
  input  wire logic           q_full,
  output sfe_pkg::q_wr_t      q_wr
);

  logic signed [31:0] sample_a;
  logic signed [31:0] sample_b;
  logic signed [31:0] sample_c;
  logic signed [31:0] sample_d;

  // Split the input item into its four channels.
  assign sample_a = in_tdata[31:0];
  assign sample_b = in_tdata[63:32];
  assign sample_c = in_tdata[95:64];
  assign sample_d = in_tdata[127:96];

  // An item is taken whenever the queue has room.
  assign in_tready = !q_full;

  // Saturate and pack little-endian, sample_a in the lowest word.
  always_comb begin
    q_wr.valid = in_tvalid && !q_full;
    q_wr.words = {sfe_pkg::clamp_word(sample_d), sfe_pkg::clamp_word(sample_c),
                  sfe_pkg::clamp_word(sample_b), sfe_pkg::clamp_word(sample_a)};
  end

endmodule

`default_nettype wire

// ===== rtl/sfe_queue.sv =====
// ----------------------------------------------------------------------------
// sfe_queue
// Small register queue that decouples the front from the back.
// ----------------------------------------------------------------------------
`default_nettype none

module sfe_queue #(
  parameter int DEPTH = sfe_pkg::QUEUE_DEPTH
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire sfe_pkg::q_wr_t  q_wr,
  output logic                 q_full,
  output sfe_pkg::q_rd_t       q_rd,
  input  wire logic            q_pop
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  sfe_pkg::frame_words_t mem_r [DEPTH];
  logic [PTR_W-1:0]      wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]      rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]      count_r, count_nxt;
  logic                  do_push;
  logic                  do_pop;

  assign q_full   = (count_r == CNT_W'(DEPTH));
  assign q_rd.valid = (count_r != '0);
  assign q_rd.words = mem_r[rd_ptr_r];

  assign do_push = q_wr.valid && !q_full;
  assign do_pop  = q_pop && q_rd.valid;

  // Pointer and fill-count update with explicit wrap.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Storage needs no reset; entries are only read after being written.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= q_wr.words;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/sfe_back.sv =====
// ----------------------------------------------------------------------------
// sfe_back
// Serializes one queued frame into ten bytes, folding each data byte
// into the CRC as it goes out, and appends the CRC.
// ----------------------------------------------------------------------------
`default_nettype none

module sfe_back (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire sfe_pkg::q_rd_t  q_rd,
  output logic                 q_pop,
  output logic                 out_tvalid,
  input  wire logic            out_tready,
  output logic [7:0]           out_tdata,
  output logic                 out_tlast
);

  localparam int IW = sfe_pkg::IDX_W;

  logic                  active_r, active_nxt;
  logic [IW-1:0]         idx_r, idx_nxt;
  logic [15:0]           crc_r, crc_nxt;
  sfe_pkg::frame_words_t words_r, words_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [7:0]            out_data_r, out_data_nxt;
  logic                  out_last_r, out_last_nxt;
  logic                  load_ok;
  logic                  emit;
  logic                  at_end;
  logic [7:0]            cur_byte;

  assign load_ok = !out_valid_r || out_tready;
  assign emit    = active_r && load_ok;
  assign at_end  = (idx_r == sfe_pkg::IDX_CRC_HI);
  assign q_pop   = q_rd.valid && (!active_r || (emit && at_end));

  // Pick the byte for the current frame position.
  always_comb begin
    if (idx_r == sfe_pkg::IDX_CRC_LO) begin
      cur_byte = crc_r[7:0];
    end else if (at_end) begin
      cur_byte = crc_r[15:8];
    end else begin
      cur_byte = words_r[{idx_r[2:0], 3'b000} +: 8];
    end
  end

  // Sequencer over the ten frame positions plus the output register.
  always_comb begin
    active_nxt    = active_r;
    idx_nxt       = idx_r;
    crc_nxt       = crc_r;
    words_nxt     = words_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    out_last_nxt  = out_last_r;

    if (emit) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = cur_byte;
      out_last_nxt  = at_end;
      if (at_end) begin
        active_nxt = 1'b0;
        idx_nxt    = sfe_pkg::IDX_FIRST;
      end else begin
        idx_nxt = idx_r + 1'b1;
      end
      if (idx_r < sfe_pkg::IDX_CRC_LO) begin
        crc_nxt = sfe_pkg::crc_byte(crc_r, cur_byte);
      end
    end else if (load_ok) begin
      out_valid_nxt = 1'b0;
    end

    // Load the next frame when idle or right behind the last byte of this one.
    if (q_pop) begin
      active_nxt = 1'b1;
      idx_nxt    = sfe_pkg::IDX_FIRST;
      crc_nxt    = sfe_pkg::CRC_INIT;
      words_nxt  = q_rd.words;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= 1'b0;
      idx_r       <= sfe_pkg::IDX_FIRST;
      out_valid_r <= 1'b0;
    end else begin
      active_r    <= active_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    crc_r      <= crc_nxt;
    words_r    <= words_nxt;
    out_data_r <= out_data_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

endmodule

`default_nettype wire

// ===== rtl/sfe_checker.sv =====
// ----------------------------------------------------------------------------
// sfe_checker
// Port-level checks for the scope frame encoder, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module sfe_checker (
  input wire logic          clk,
  input wire logic          rst_n,
  input wire logic          in_tvalid,
  input wire logic          in_tready,
  input wire logic          out_tvalid,
  input wire logic          out_tready,
  input wire logic [7:0]    out_tdata,
  input wire logic          out_tlast
);

  logic       in_acc;
  logic       out_acc;
  logic [3:0] byte_cnt_r;
  logic [3:0] pending_r;

  assign in_acc  = in_tvalid && in_tready;
  assign out_acc = out_tvalid && out_tready;

  // Position of the next byte within the frame.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_cnt_r <= '0;
    end else if (out_acc) begin
      byte_cnt_r <= out_tlast ? 4'd0 : byte_cnt_r + 4'd1;
    end
  end

  // Items taken whose frames are not yet fully sent.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= '0;
    end else begin
      pending_r <= pending_r + {3'b000, in_acc} - {3'b000, out_acc && out_tlast};
    end
  end

  // A stalled byte holds its value.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("output byte changed while stalled");

  // Reset drops the output.
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("out_tvalid high after reset");

  // Every frame is exactly ten bytes with tlast on the tenth.
  a_frame_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tlast == (byte_cnt_r == 4'd9)))
    else $error("frame length or tlast position wrong");

  // No byte goes out without an item behind it.
  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (pending_r != 4'd0))
    else $error("output byte without a pending item");

endmodule

bind scope_frame_encoder_crc16 sfe_checker u_sfe_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);

`default_nettype wire

// ===== sim/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the four-channel scope frame encoder.
// ----------------------------------------------------------------------------
// Items of four signed samples go in on the input stream. For each accepted
// item a local predictor saturates the samples, packs the frame and runs the
// reflected CRC-16. It then queues the ten expected bytes. A monitor compares
// every byte taken from the output stream with the oldest queued byte. The
// tests cover directed sample extremes and random sample sets. Both sides
// idle at random. One test stalls the receiver for a long time so that the
// input backs up. Another drains the whole pipeline before it goes on.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  // Saturation limits and CRC settings of the frame format.
  localparam logic signed [31:0] SAT_HI    = 32'sd32767;
  localparam logic signed [31:0] SAT_LO    = -32'sd32767;
  localparam logic [15:0]        CRC_SEED  = 16'hFFFF;
  localparam logic [15:0]        CRC_TAPS  = 16'hA001;
  localparam int                 BYTES_PER_FRAME = 10;
  localparam int                 TAIL_CYCLES     = 30;
  localparam int                 MAX_REPORTS     = 10;

  typedef struct {
    logic [7:0] data;
    logic       last;
  } frame_byte_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [127:0] in_tdata = '0;   // sample_a[31:0], sample_b, sample_c, sample_d
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [7:0]   out_tdata;       // frame_byte[7:0]
  logic         out_tlast;       // frame_end

  frame_byte_t  expected_bytes[$];
  int           error_count = 0;
  bit           idling_on = 1'b1;
  int           hold_off_left = 0;
  int           stall_left = 0;

  scope_frame_encoder_crc16 uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  // 10 ns clock.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Saturate one sample to the symmetric 16-bit range and return its word.
  function automatic logic [15:0] saturate_sample(input logic signed [31:0] s);
    logic signed [31:0] v;
    v = s;
    if (v > SAT_HI) begin
      v = SAT_HI;
    end
    if (v < SAT_LO) begin
      v = SAT_LO;
    end
    return v[15:0];
  endfunction

  // Shift one byte into the reflected CRC, one bit at a time from the LSB.
  function automatic logic [15:0] crc16_add_byte(input logic [15:0] crc,
                                                 input logic [7:0] b);
    logic [15:0] c;
    logic        fb;
    c = crc;
    for (int i = 0; i < 8; i++) begin
      fb = c[0] ^ b[i];
      c = c >> 1;
      if (fb) begin
        c = c ^ CRC_TAPS;
      end
    end
    return c;
  endfunction

  // Build the ten bytes that one sample set must produce and queue them.
  function automatic void queue_frame(input logic [127:0] samples);
    logic [7:0]  frame[BYTES_PER_FRAME];
    logic [15:0] word;
    logic [15:0] crc;
    frame_byte_t fb;
    crc = CRC_SEED;
    for (int ch = 0; ch < 4; ch++) begin
      word = saturate_sample(samples[32*ch +: 32]);
      frame[2*ch]     = word[7:0];
      frame[2*ch + 1] = word[15:8];
    end
    for (int k = 0; k < 8; k++) begin
      crc = crc16_add_byte(crc, frame[k]);
    end
    frame[8] = crc[7:0];
    frame[9] = crc[15:8];
    for (int k = 0; k < BYTES_PER_FRAME; k++) begin
      fb.data = frame[k];
      fb.last = (k == BYTES_PER_FRAME - 1);
      expected_bytes.push_back(fb);
    end
  endfunction

  // Gap length: mostly none or short, now and then long.
  function automatic int pick_gap();
    int r;
    if (!idling_on) begin
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 55) begin
      return 0;
    end else if (r < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(4, 20);
  endfunction

  // Random sample, weighted toward the saturation edges.
  function automatic logic [31:0] pick_sample();
    case ($urandom_range(0, 5))
      0:       return $urandom;
      1:       return 32'($signed($urandom_range(0, 200)) - 100);
      2:       return 32'(SAT_HI + $signed($urandom_range(0, 6)) - 3);
      3:       return 32'(SAT_LO + $signed($urandom_range(0, 6)) - 3);
      4:       return 32'($signed($urandom_range(0, 65535)) - 32768);
      default: return {$urandom_range(0, 1) ? 1'b1 : 1'b0, 31'($urandom)};
    endcase
  endfunction

  function automatic void note_error(input string msg);
    error_count++;
    if (error_count <= MAX_REPORTS) begin
      $display("ERROR at %0t: %s", $realtime, msg);
    end
  endfunction

  // Offer one item after an optional gap and wait until it is taken.
  task automatic send_samples(input logic [31:0] a, input logic [31:0] b,
                              input logic [31:0] c, input logic [31:0] d);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {d, c, b, a};
    do @(posedge clk); while (!in_tready);
    queue_frame({d, c, b, a});
  endtask

  // Stop offering and wait until every queued byte has come out.
  task automatic drain_frames();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (expected_bytes.size() != 0);
  endtask

  // Receiver: long hold-off when asked, else random stalls.
  initial begin
    @(posedge clk);
    forever begin
      if (hold_off_left > 0) begin
        hold_off_left--;
        out_tready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
        if (idling_on && $urandom_range(0, 99) < 25) begin
          stall_left = pick_gap();
        end
      end
      @(posedge clk);
    end
  end

  // Compare every byte taken from the output with the oldest expected byte.
  always @(posedge clk) begin
    frame_byte_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_bytes.size() == 0) begin
        note_error($sformatf("unexpected byte %02h last=%0b", out_tdata, out_tlast));
      end else begin
        want = expected_bytes.pop_front();
        if (out_tdata !== want.data || out_tlast !== want.last) begin
          note_error($sformatf("byte exp %02h last=%0b, got %02h last=%0b",
                               want.data, want.last, out_tdata, out_tlast));
        end
      end
    end
  end

  // Sample extremes and each saturation edge.
  task automatic test_sample_extremes();
    send_samples(32'sd0, 32'sd0, 32'sd0, 32'sd0);
    send_samples(32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF);
    send_samples(32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh80000000);
    send_samples(-32'sd32768, -32'sd32767, -32'sd32769, -32'sd32766);
    send_samples(32'sd32767, 32'sd32768, 32'sd32766, 32'sd65536);
    send_samples(-32'sd1, 32'sd1, -32'sd2, 32'sd2);
    send_samples(32'hFFFFFFFF, 32'h0000FFFF, 32'hFFFF0000, 32'h00008000);
    send_samples(32'sh7FFFFFFF, 32'sh80000000, 32'sd0, -32'sd32768);
    send_samples(32'h00007FFF, 32'hFFFF8001, 32'h00000100, 32'hFFFFFF00);
    send_samples(32'h55555555, 32'hAAAAAAAA, 32'h00005555, 32'hFFFFAAAA);
    send_samples(32'sd12345, -32'sd12345, 32'sd255, -32'sd256);
    send_samples(32'hFFFF7FFF, 32'h00018000, 32'h80007FFF, 32'h7FFF8000);
  endtask

  // Random sample sets with random gaps on both sides; one full drain midway.
  task automatic test_random_frames(input int count);
    for (int i = 0; i < count; i++) begin
      send_samples(pick_sample(), pick_sample(), pick_sample(), pick_sample());
      if (i == count / 2) begin
        drain_frames();
      end
    end
  endtask

  // Receiver holds off while the sender keeps offering, so the input stalls.
  task automatic test_output_backpressure();
    idling_on = 1'b0;
    hold_off_left = 120;
    for (int i = 0; i < 12; i++) begin
      send_samples(pick_sample(), pick_sample(), pick_sample(), pick_sample());
    end
    idling_on = 1'b1;
  endtask

  // Back-to-back items with a receiver that never stalls.
  task automatic test_full_rate();
    idling_on = 1'b0;
    stall_left = 0;
    for (int i = 0; i < 20; i++) begin
      send_samples($urandom, pick_sample(), $urandom, pick_sample());
    end
    idling_on = 1'b1;
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_sample_extremes();
    test_random_frames(190);
    test_output_backpressure();
    test_full_rate();
    test_random_frames(190);
    in_tvalid <= 1'b0;
    do @(posedge clk); while (expected_bytes.size() != 0);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Watchdog for a hung pipeline.
  initial begin
    #5_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
